[rtl/slrg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrg_pkg
// Shared constants and the controller-to-datapath command bundle of the
// shuffled Lehmer random generator.
// ----------------------------------------------------------------------------
package slrg_pkg;

  // Generator word and Lehmer constants (modulus 2^31 - 1, multiplier 16807).
  localparam int unsigned DATA_W       = 31;
  localparam int unsigned MULT_W       = 15;
  localparam int unsigned PROD_W       = DATA_W + MULT_W;
  localparam logic [DATA_W-1:0] MODULUS = 31'h7FFF_FFFF;
  localparam logic [MULT_W-1:0] MULT    = 15'd16807;

  // Generator steps thrown away after a reseed, before the table fill.
  localparam int unsigned WARMUP_STEPS = 8;

  // Commands from the sequencer to the datapath.
  typedef struct packed {
    logic load_seed;  // load the generator state from the seed path
    logic seed_one;   // force the loaded seed to 1 (first use)
    logic step;       // state <= state * MULT mod MODULUS
    logic fill_wr;    // write the new state into the table at the fill index
    logic fill_last;  // last fill step: new state also becomes last output
    logic rd_en;      // read the table at the shuffle index
    logic commit;     // take the read entry as result, store state in its place
  } dp_cmd_t;

endpackage

[rtl/slrg_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrg_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module slrg_ram #(
  parameter int unsigned WIDTH = 31,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

[rtl/slrg_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrg_dp
// Datapath: generator state, modular multiply, shuffle index and table.
// ----------------------------------------------------------------------------
module slrg_dp #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  slrg_pkg::dp_cmd_t           cmd,
  input  logic [slrg_pkg::DATA_W-1:0] in_seed,
  output logic                        need_init,
  output logic [slrg_pkg::DATA_W-1:0] value
);

  localparam int unsigned DW    = slrg_pkg::DATA_W;
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);
  localparam int unsigned Q_W   = IDX_W + 1;
  localparam int unsigned PQ_W  = DW + Q_W;
  localparam int unsigned REM_W = DW + Q_W;

  // Shuffle index divisor 1 + (2^31 - 2) / entries, and a reciprocal that
  // never overestimates the quotient and falls short by at most one step.
  localparam longint unsigned DIV_L   = 64'd1 + (64'h7FFF_FFFE / TABLE_ENTRIES);
  localparam longint unsigned RECIP_L = 64'h8000_0000 / DIV_L;
  localparam logic [DW-1:0]   DIV_C   = DW'(DIV_L);
  localparam logic [Q_W-1:0]  RECIP_C = Q_W'(RECIP_L);

  logic [DW-1:0]    state_r, state_nxt;
  logic [DW-1:0]    last_r, last_nxt;
  logic [DW-1:0]    last_d_r;
  logic [slrg_pkg::PROD_W-1:0] prod_r;
  logic [Q_W-1:0]   qest_r;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [IDX_W-1:0] fill_idx_r, fill_idx_nxt;
  logic [DW-1:0]    value_r, value_nxt;

  logic [DW-1:0]    seed_fix;
  logic [DW:0]      fold;
  logic [DW-1:0]    red;
  logic [PQ_W-1:0]  qprod;
  logic [REM_W-1:0] qd;
  logic [REM_W-1:0] rem;
  logic [Q_W-1:0]   q_corr;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [DW-1:0]    ram_wdata;
  logic [DW-1:0]    ram_rdata;

  // A seed of zero or equal to the modulus reduces to zero and becomes 1.
  assign seed_fix = (cmd.seed_one || (in_seed == '0) || (in_seed == slrg_pkg::MODULUS))
                    ? DW'(1) : in_seed;

  // Mersenne fold of the registered product, then one conditional subtract.
  assign fold = {1'b0, prod_r[DW-1:0]} + (DW + 1)'(prod_r[slrg_pkg::PROD_W-1:DW]);
  assign red  = (fold >= (DW + 1)'(slrg_pkg::MODULUS))
                ? DW'(fold - (DW + 1)'(slrg_pkg::MODULUS)) : fold[DW-1:0];

  // Shuffle index: reciprocal estimate, then one remainder correction.
  assign qprod  = PQ_W'(last_r) * PQ_W'(RECIP_C);
  assign qd     = REM_W'(qest_r) * REM_W'(DIV_C);
  assign rem    = REM_W'(last_d_r) - qd;
  assign q_corr = (rem >= REM_W'(DIV_C)) ? qest_r + Q_W'(1) : qest_r;
  assign idx_nxt = (q_corr >= Q_W'(TABLE_ENTRIES)) ? IDX_W'(TABLE_ENTRIES - 1)
                                                   : q_corr[IDX_W-1:0];

  always_comb begin
    state_nxt    = state_r;
    last_nxt     = last_r;
    fill_idx_nxt = fill_idx_r;
    value_nxt    = value_r;
    if (cmd.load_seed) begin
      state_nxt    = seed_fix;
      fill_idx_nxt = IDX_W'(TABLE_ENTRIES - 1);
    end
    if (cmd.step) begin
      state_nxt = red;
    end
    if (cmd.fill_wr) begin
      fill_idx_nxt = fill_idx_r - IDX_W'(1);
    end
    if (cmd.fill_last) begin
      last_nxt = red;
    end
    if (cmd.commit) begin
      last_nxt  = ram_rdata;
      value_nxt = ram_rdata;
    end
  end

  assign ram_we    = cmd.fill_wr || cmd.commit;
  assign ram_waddr = cmd.fill_wr ? fill_idx_r : idx_r;
  assign ram_wdata = cmd.fill_wr ? red : state_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      last_r  <= '0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r     <= slrg_pkg::PROD_W'(state_r) * slrg_pkg::PROD_W'(slrg_pkg::MULT);
    qest_r     <= qprod[PQ_W-1:DW];
    last_d_r   <= last_r;
    idx_r      <= idx_nxt;
    fill_idx_r <= fill_idx_nxt;
    value_r    <= value_nxt;
  end

  slrg_ram #(
    .WIDTH (DW),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (cmd.rd_en),
    .raddr   (idx_r),
    .rdata_r (ram_rdata)
  );

  assign need_init = (last_r == '0) || (state_r == '0);
  assign value     = value_r;

endmodule

[rtl/slrg_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slrg_ctrl
// Sequencer for reseed, warm-up, table fill and draw, plus output handshake.
// ----------------------------------------------------------------------------
module slrg_ctrl #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  input  logic              in_op,
  output logic              in_tready,
  input  logic              need_init,
  input  logic              out_tready,
  output logic              out_tvalid,
  output slrg_pkg::dp_cmd_t cmd
);

  localparam int unsigned TOTAL_STEPS = slrg_pkg::WARMUP_STEPS + TABLE_ENTRIES;
  localparam int unsigned CNT_W       = $clog2(TOTAL_STEPS);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_RED   = 3'd2;
  localparam logic [2:0] ST_SETTLE = 3'd3;
  localparam logic [2:0] ST_STEP  = 3'd4;
  localparam logic [2:0] ST_READ  = 3'd5;
  localparam logic [2:0] ST_DONE  = 3'd6;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_op || need_init) begin
            cmd.load_seed = 1'b1;
            cmd.seed_one  = !in_op;
            cnt_nxt       = '0;
            state_nxt     = ST_MUL;
          end else begin
            state_nxt = ST_STEP;
          end
        end
      end
      ST_MUL: begin
        state_nxt = ST_RED;
      end
      ST_RED: begin
        cmd.step    = 1'b1;
        cmd.fill_wr = (cnt_r >= CNT_W'(slrg_pkg::WARMUP_STEPS));
        if (cnt_r == CNT_W'(TOTAL_STEPS - 1)) begin
          cmd.fill_last = 1'b1;
          state_nxt     = ST_SETTLE;
        end else begin
          cnt_nxt   = cnt_r + CNT_W'(1);
          state_nxt = ST_MUL;
        end
      end
      ST_SETTLE: begin
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        cmd.step  = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_tready) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // A result never overwrites one that is still waiting.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || out_tready))
    else $error("result committed over a pending result");

  // The step counter never runs past the last table fill step.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RED) |-> (cnt_r <= CNT_W'(TOTAL_STEPS - 1)))
    else $error("init step counter overrun");

  // A commit is followed by a pending result and a free input.
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("commit did not present a result");

  // A reseed always enters the generator warm-up.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_op) |=> ((state_r == ST_MUL) && (cnt_r == '0)))
    else $error("reseed did not start the warm-up");

endmodule

[rtl/shuffled_lehmer_random_generator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shuffled_lehmer_random_generator_core
// Park-Miller minimal standard generator behind a Bays-Durham shuffle table.
// ----------------------------------------------------------------------------
// Usage:
//   Each input transaction asks for one random value. in_tuser[0] is the
//   operation: 0 draws the next value, 1 reseeds from in_tdata and then
//   draws. Every input transaction yields exactly one output transaction
//   whose out_tdata carries an integer in 1 .. 2^31 - 2; the uniform
//   fraction is that value divided by 2^31 - 1.
// Draw and reseed:
//   The block takes a new transaction only once the last result has been
//   committed and it is back in idle. A plain draw steps the generator
//   through the registered modular multiply, reads the table RAM at the
//   index from the shuffle index unit and writes the generator state
//   into the read entry when the result commits. A reseed, or the first
//   draw after reset, runs 8 warm-up steps and TABLE_ENTRIES fill steps
//   on the shared multiplier before it draws.
// Reset and stalls:
//   Reset clears the generator state and the last output, so the first
//   draw seeds with 1. The table needs no clearing since it is always
//   filled before it is read. A new transaction is accepted while an
//   earlier result waits in the output register; the next result then
//   waits until the receiver takes the pending one.
// ----------------------------------------------------------------------------
module shuffled_lehmer_random_generator_core #(
  parameter int unsigned TABLE_ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [30:0] seed, [31] zero fill
  input  logic [0:0]  in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [30:0] value, [31] zero fill
);

  slrg_pkg::dp_cmd_t             cmd;
  logic                          need_init;
  logic [slrg_pkg::DATA_W-1:0]   value;

  slrg_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser[0]),
    .in_tready  (in_tready),
    .need_init  (need_init),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd)
  );

  slrg_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_seed   (in_tdata[30:0]),
    .need_init (need_init),
    .value     (value)
  );

  assign out_tdata = {1'b0, value};

endmodule
